[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/ppg_pkg.sv]
// ----------------------------------------------------------------------------
// ppg_pkg
// Types and fixed constants of the plasma pixel generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

    // Width of a pixel coordinate; the payload fields carry exactly this many bits.
    localparam int COORD_BITS = 10;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic       frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] bright;
    } t_pixel_out;

    typedef enum logic [2:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_DRIFT_X    = 3'd1,
        CFG_DRIFT_Y    = 3'd2,
        CFG_SCALE_A    = 3'd3,
        CFG_SCALE_B    = 3'd4,
        CFG_LEVELS     = 3'd5,
        CFG_BRIGHT_MAP = 3'd6,
        CFG_HUE_MAP    = 3'd7
    } t_cfg_idx;

    localparam int CFG_W = 40;

    localparam logic [31:0] RST_TIME_STEP  = 32'd65536;
    localparam logic [15:0] RST_DRIFT      = 16'd256;
    localparam logic [15:0] RST_SCALE      = 16'd4096;
    localparam logic [7:0]  RST_LEVELS     = 8'd8;
    localparam logic [31:0] RST_BRIGHT_MAP = 32'd16711680;
    localparam logic [39:0] RST_HUE_MAP    = 40'd1095216660480;

    // Fixed-point constants: 2*pi in Q16, 1/(2*pi) in Q0.32, pi/2 and one in Q30.
    localparam logic [19:0] TWO_PI_Q16     = 20'd411775;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0] ONE_Q30        = 64'd1073741824;

    // Fixed points in Q.8 pixels.
    localparam int Q8_128 = 32768;
    localparam int Q8_192 = 49152;
    localparam int Q8_64  = 16384;

    localparam longint DIFF_MAX = 64'sd2147483647;

    // Level division: magnitude of q*range fits 23 bits.
    localparam int MAG_W = 23;

    // Added to a hue before reduction so that it is never negative (255*258).
    localparam logic [17:0] HUE_BIAS = 18'd65790;

endpackage

[design/ppg_sine_term.sv]
// ----------------------------------------------------------------------------
// ppg_sine_term
// Pipelined sin(sqrt(dx^2+dy^2)/scale): square, root, divide with modulo 2*pi,
// phase to table index, quarter-wave table lookup.
// ----------------------------------------------------------------------------
module ppg_sine_term #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic signed [31:0] i_dx,
    input  logic signed [31:0] i_dy,
    input  logic [15:0]        i_scale,
    output logic               o_valid,
    output logic signed [15:0] o_sine
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 48;
    localparam int LAT       = SQ_STEPS + DIV_STEPS + 7;
    localparam int IDX_W     = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int AW        = $clog2(SINE_TABLE_DEPTH + 1);

    logic [LAT-1:0] r_vld;

    logic [30:0] w_ax, w_ay;
    logic [61:0] r_dx2, r_dy2;
    logic [63:0] r_sq;

    logic [63:0] r_sn    [SQ_STEPS];
    logic [33:0] r_srem  [SQ_STEPS];
    logic [31:0] r_sroot [SQ_STEPS];

    logic [15:0] w_den;
    logic [47:0] r_dnum [DIV_STEPS];
    logic [15:0] r_drem [DIV_STEPS];
    logic [18:0] r_dqm  [DIV_STEPS];

    logic [63:0]      w_tprod, w_iprod;
    logic [31:0]      r_turns;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] w_r;
    logic             w_odd, w_neg;
    logic [AW-1:0]    w_raw, r_addr;
    logic             r_neg_a, r_neg_t;
    logic [14:0]      r_tab;
    logic signed [15:0] r_sine;

    logic [14:0] w_qtab [SINE_TABLE_DEPTH + 1];

    // Quarter-wave sine table, Q30 Taylor series to degree 11, rounded to Q15.
    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_tab
        localparam logic [63:0] X  = (ppg_pkg::HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] F1 = ppg_pkg::ONE_Q30 - X2 / 110;
        localparam logic [63:0] F2 = ppg_pkg::ONE_Q30 - ((X2 * F1) >> 30) / 72;
        localparam logic [63:0] F3 = ppg_pkg::ONE_Q30 - ((X2 * F2) >> 30) / 42;
        localparam logic [63:0] F4 = ppg_pkg::ONE_Q30 - ((X2 * F3) >> 30) / 20;
        localparam logic [63:0] F5 = ppg_pkg::ONE_Q30 - ((X2 * F4) >> 30) / 6;
        localparam logic [63:0] S  = (X * F5) >> 30;
        localparam logic [63:0] E  = (S + 64'd16384) >> 15;
        assign w_qtab[i] = (E > 64'd32767) ? 15'd32767 : E[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[LAT-1];

    // Differences are saturated to +-(2^31-1), so the magnitude fits 31 bits.
    assign w_ax = 31'(i_dx[31] ? -i_dx : i_dx);
    assign w_ay = 31'(i_dy[31] ? -i_dy : i_dy);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx2 <= 62'(w_ax) * 62'(w_ax);
            r_dy2 <= 62'(w_ay) * 62'(w_ay);
            r_sq  <= 64'(r_dx2) + 64'(r_dy2);
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [63:0] w_n;
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [35:0] w_rs, w_trial;
        logic        w_ge;
        if (k == 0) begin : g_first
            assign w_n    = r_sq;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_n    = r_sn[k-1];
            assign w_rem  = r_srem[k-1];
            assign w_root = r_sroot[k-1];
        end
        assign w_rs    = {w_rem, w_n[63:62]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = (w_rs >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_sn[k]    <= w_n << 2;
                r_srem[k]  <= w_ge ? 34'(w_rs - w_trial) : w_rs[33:0];
                r_sroot[k] <= {w_root[30:0], w_ge};
            end
        end
    end

    assign w_den = (i_scale == 16'd0) ? 16'd1 : i_scale;

    // Restoring division of dist*2^16 by the scale. Only the quotient modulo
    // 2*pi is kept, updated as each quotient bit appears.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [47:0] w_num;
        logic [15:0] w_rem;
        logic [18:0] w_qm;
        logic [16:0] w_rs;
        logic [19:0] w_qm2;
        logic        w_ge;
        if (k == 0) begin : g_first
            assign w_num = {r_sroot[SQ_STEPS-1], 16'd0};
            assign w_rem = '0;
            assign w_qm  = '0;
        end else begin : g_next
            assign w_num = r_dnum[k-1];
            assign w_rem = r_drem[k-1];
            assign w_qm  = r_dqm[k-1];
        end
        assign w_rs  = {w_rem, w_num[47]};
        assign w_ge  = (w_rs >= {1'b0, w_den});
        assign w_qm2 = {w_qm, w_ge};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dnum[k] <= w_num << 1;
                r_drem[k] <= w_ge ? 16'(w_rs - {1'b0, w_den}) : w_rs[15:0];
                r_dqm[k]  <= (w_qm2 >= ppg_pkg::TWO_PI_Q16) ?
                             19'(w_qm2 - ppg_pkg::TWO_PI_Q16) : w_qm2[18:0];
            end
        end
    end

    assign w_tprod = 64'(r_dqm[DIV_STEPS-1]) * 64'(ppg_pkg::INV_TWO_PI_Q32);
    assign w_iprod = 64'(r_turns) * 64'(4 * SINE_TABLE_DEPTH);

    always_comb begin
        w_odd = 1'b0;
        w_neg = 1'b0;
        w_r   = r_idx;
        priority if (r_idx >= IDX_W'(3 * SINE_TABLE_DEPTH)) begin
            w_odd = 1'b1;
            w_neg = 1'b1;
            w_r   = r_idx - IDX_W'(3 * SINE_TABLE_DEPTH);
        end else if (r_idx >= IDX_W'(2 * SINE_TABLE_DEPTH)) begin
            w_neg = 1'b1;
            w_r   = r_idx - IDX_W'(2 * SINE_TABLE_DEPTH);
        end else if (r_idx >= IDX_W'(SINE_TABLE_DEPTH)) begin
            w_odd = 1'b1;
            w_r   = r_idx - IDX_W'(SINE_TABLE_DEPTH);
        end else begin
            w_r   = r_idx;
        end
        w_raw = AW'(w_r);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_turns <= w_tprod[47:16];
            r_idx   <= w_iprod[32 +: IDX_W];
            r_addr  <= w_odd ? AW'(SINE_TABLE_DEPTH) - w_raw : w_raw;
            r_neg_a <= w_neg;
            r_tab   <= w_qtab[r_addr];
            r_neg_t <= r_neg_a;
            r_sine  <= r_neg_t ? -$signed({1'b0, r_tab}) : $signed({1'b0, r_tab});
        end
    end
    assign o_sine = r_sine;

endmodule

[design/plasma_pixel_generator.sv]
// ----------------------------------------------------------------------------
// plasma_pixel_generator
// Plasma colour (hue, saturation, brightness) of one pixel per item.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (pixel_x, pixel_y, frame_start)
// out     | output    | o_out_valid / i_out_stall | o_out_data (hue, sat, bright)
// cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One item per clock while no stalled result holds the pipeline. Stages for any
// SINE_TABLE_DEPTH: entry and offset (3), sine-term pipeline (87: 32 root steps,
// 48 divide steps), level quantization (3), the level divider (23), output (2).
// Frame time advances at entry when an item with frame_start is accepted.
// Reset clears valids and frame time and loads the register defaults.
// A waiting result with i_out_stall high freezes the whole pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plasma_pixel_generator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRAC_BITS        = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ppg_pkg::t_pixel_in         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ppg_pkg::t_pixel_out        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [ppg_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int OFF_W = 49 - FRAC_BITS;
    localparam int DW    = (OFF_W + 2 > 33) ? OFF_W + 2 : 33;
    localparam int MW    = ppg_pkg::MAG_W;

    // Configuration.
    logic [31:0] r_time_step;
    logic [15:0] r_drift_x, r_drift_y, r_scale_a, r_scale_b;
    logic [7:0]  r_levels;
    logic [31:0] r_bright_map;
    logic [39:0] r_hue_map;
    logic [31:0] r_frame_time;

    logic w_adv, w_in_acc;

    logic        r_v1, r_v2, r_v3, r_s1v, r_s2v, r_s3v, r_f1v, r_out_valid;
    logic [MW-1:0] r_dvld;
    logic [3:0]  w_tvld;

    logic [9:0]  w_cmask;
    logic [17:0] r1_x, r1_y, r2_x, r2_y;
    logic [31:0] r1_ft;
    logic [31:0] w_ft_next;

    logic [16:0]            w_mag_x, w_mag_y;
    logic [48:0]            w_mx, w_my;
    logic [OFF_W-1:0]       w_ox, w_oy;
    logic signed [OFF_W:0]  r2_offx, r2_offy;

    logic signed [DW-1:0] w_sx, w_sy;
    logic signed [31:0]   w_satx, w_saty;
    logic signed [31:0]   r3_dx [4];
    logic signed [31:0]   r3_dy [4];
    logic signed [15:0]   w_sine [4];

    logic signed [18:0] w_sum;
    logic [14:0] r_v15;
    logic [7:0]  w_lv, r_q;
    logic [22:0] w_qprod;

    logic signed [15:0] w_rng [2];
    logic signed [15:0] w_off [2];
    logic [MW-1:0] r_dv_num [2][MW];
    logic [7:0]    r_dv_rem [2][MW];
    logic [MW-1:0] r_dv_quo [2][MW];
    logic          r_dv_neg [2][MW];
    logic [MW-1:0] r_mag [2];
    logic          r_neg [2];
    logic signed [17:0] r_tot [2];

    logic [17:0] w_hu;
    logic [9:0]  w_hf1;
    logic [8:0]  w_hf2;
    logic [7:0]  w_hue, w_bright;
    ppg_pkg::t_pixel_out r_out;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_in_acc   = i_in_valid && w_adv;
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= ppg_pkg::RST_TIME_STEP;
            r_drift_x    <= ppg_pkg::RST_DRIFT;
            r_drift_y    <= ppg_pkg::RST_DRIFT;
            r_scale_a    <= ppg_pkg::RST_SCALE;
            r_scale_b    <= ppg_pkg::RST_SCALE;
            r_levels     <= ppg_pkg::RST_LEVELS;
            r_bright_map <= ppg_pkg::RST_BRIGHT_MAP;
            r_hue_map    <= ppg_pkg::RST_HUE_MAP;
        end else if (i_cfg_we) begin
            unique case (ppg_pkg::t_cfg_idx'(i_cfg_idx))
                ppg_pkg::CFG_TIME_STEP:  r_time_step  <= i_cfg_data[31:0];
                ppg_pkg::CFG_DRIFT_X:    r_drift_x    <= i_cfg_data[15:0];
                ppg_pkg::CFG_DRIFT_Y:    r_drift_y    <= i_cfg_data[15:0];
                ppg_pkg::CFG_SCALE_A:    r_scale_a    <= i_cfg_data[15:0];
                ppg_pkg::CFG_SCALE_B:    r_scale_b    <= i_cfg_data[15:0];
                ppg_pkg::CFG_LEVELS:     r_levels     <= i_cfg_data[7:0];
                ppg_pkg::CFG_BRIGHT_MAP: r_bright_map <= i_cfg_data[31:0];
                ppg_pkg::CFG_HUE_MAP:    r_hue_map    <= i_cfg_data[39:0];
            endcase
        end
    end

    // Valid bits travel with the data and all shift together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
            r_dvld <= '0;
            r_f1v <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            if (i_in_valid) begin
                r_frame_time <= w_ft_next;
            end
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_s1v <= w_tvld[0];
            r_s2v <= r_s1v;
            r_s3v <= r_s2v;
            r_dvld <= {r_dvld[MW-2:0], r_s3v};
            r_f1v <= r_dvld[MW-1];
            r_out_valid <= r_f1v;
        end
    end

    assign w_cmask   = 10'((32'd1 << ppg_pkg::COORD_BITS) - 32'd1);
    assign w_ft_next = i_in_data.frame_start ? r_frame_time + r_time_step : r_frame_time;

    // Time shift magnitudes: |drift| * frame_time >> FRAC_BITS.
    assign w_mag_x = r_drift_x[15] ? 17'({1'b0, ~r_drift_x}) + 17'd1 : {1'b0, r_drift_x};
    assign w_mag_y = r_drift_y[15] ? 17'({1'b0, ~r_drift_y}) + 17'd1 : {1'b0, r_drift_y};
    assign w_mx    = 49'(w_mag_x) * 49'(r1_ft);
    assign w_my    = 49'(w_mag_y) * 49'(r1_ft);
    assign w_ox    = OFF_W'(w_mx >> FRAC_BITS);
    assign w_oy    = OFF_W'(w_my >> FRAC_BITS);

    assign w_sx = DW'($signed({1'b0, r2_x})) + DW'(r2_offx) - DW'(ppg_pkg::Q8_128);
    assign w_sy = DW'($signed({1'b0, r2_y})) + DW'(r2_offy) - DW'(ppg_pkg::Q8_64);

    always_comb begin
        priority if (w_sx > DW'(ppg_pkg::DIFF_MAX)) begin
            w_satx = 32'(ppg_pkg::DIFF_MAX);
        end else if (w_sx < -DW'(ppg_pkg::DIFF_MAX)) begin
            w_satx = -32'(ppg_pkg::DIFF_MAX);
        end else begin
            w_satx = 32'(w_sx);
        end
        priority if (w_sy > DW'(ppg_pkg::DIFF_MAX)) begin
            w_saty = 32'(ppg_pkg::DIFF_MAX);
        end else if (w_sy < -DW'(ppg_pkg::DIFF_MAX)) begin
            w_saty = -32'(ppg_pkg::DIFF_MAX);
        end else begin
            w_saty = 32'(w_sy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x    <= {i_in_data.pixel_x & w_cmask, 8'd0};
            r1_y    <= {i_in_data.pixel_y & w_cmask, 8'd0};
            r1_ft   <= w_ft_next;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_offx <= r_drift_x[15] ? -$signed({1'b0, w_ox}) : $signed({1'b0, w_ox});
            r2_offy <= r_drift_y[15] ? -$signed({1'b0, w_oy}) : $signed({1'b0, w_oy});
            r3_dx[0] <= w_satx;
            r3_dy[0] <= $signed({14'd0, r2_y}) - 32'(ppg_pkg::Q8_128);
            r3_dx[1] <= $signed({14'd0, r2_x});
            r3_dy[1] <= $signed({14'd0, r2_y});
            r3_dx[2] <= $signed({14'd0, r2_x}) - 32'(ppg_pkg::Q8_192);
            r3_dy[2] <= $signed({14'd0, r2_y}) - 32'(ppg_pkg::Q8_64);
            r3_dx[3] <= $signed({14'd0, r2_x}) - 32'(ppg_pkg::Q8_192);
            r3_dy[3] <= w_saty;
        end
    end

    for (genvar t = 0; t < 4; t++) begin : g_term
        ppg_sine_term #(
            .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (r_v3),
            .i_dx    (r3_dx[t]),
            .i_dy    (r3_dy[t]),
            .i_scale ((t < 2) ? r_scale_a : r_scale_b),
            .o_valid (w_tvld[t]),
            .o_sine  (w_sine[t])
        );
    end

    // Sum of four sines, shifted into 0..1 as Q0.15.
    assign w_sum = 19'(w_sine[0]) + 19'(w_sine[1]) + 19'(w_sine[2]) + 19'(w_sine[3])
                 + 19'sd131072;
    assign w_lv    = (r_levels == 8'd0) ? 8'd1 : r_levels;
    assign w_qprod = 23'(w_lv) * 23'(r_v15) + 23'd16384;

    assign w_rng[0] = $signed(r_bright_map[31:16]);
    assign w_rng[1] = $signed(r_hue_map[31:16]);
    assign w_off[0] = $signed(r_bright_map[15:0]);
    assign w_off[1] = $signed(r_hue_map[15:0]);

    // floor((off*lv + q*rng)/lv) = off + floor(q*rng/lv): a division of the
    // magnitude of q*rng by the level count, one quotient bit per stage.
    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [24:0] w_p;
        logic [MW-1:0]      w_qf;
        logic               w_nz;
        logic signed [17:0] w_fq;

        assign w_p = $signed({1'b0, r_q}) * w_rng[l];

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mag[l] <= MW'(w_p[24] ? -w_p : w_p);
                r_neg[l] <= w_p[24];
            end
        end

        for (genvar k = 0; k < MW; k++) begin : g_step
            logic [MW-1:0] w_num, w_quo;
            logic [7:0]    w_rem;
            logic          w_sgn;
            logic [8:0]    w_rs;
            logic          w_ge;
            if (k == 0) begin : g_first
                assign w_num = r_mag[l];
                assign w_rem = '0;
                assign w_quo = '0;
                assign w_sgn = r_neg[l];
            end else begin : g_next
                assign w_num = r_dv_num[l][k-1];
                assign w_rem = r_dv_rem[l][k-1];
                assign w_quo = r_dv_quo[l][k-1];
                assign w_sgn = r_dv_neg[l][k-1];
            end
            assign w_rs = {w_rem, w_num[MW-1]};
            assign w_ge = (w_rs >= {1'b0, w_lv});
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dv_num[l][k] <= w_num << 1;
                    r_dv_rem[l][k] <= w_ge ? 8'(w_rs - {1'b0, w_lv}) : w_rs[7:0];
                    r_dv_quo[l][k] <= {w_quo[MW-2:0], w_ge};
                    r_dv_neg[l][k] <= w_sgn;
                end
            end
        end

        // Round toward minus infinity for a negative dividend.
        assign w_qf = r_dv_quo[l][MW-1];
        assign w_nz = (r_dv_rem[l][MW-1] != 8'd0);
        assign w_fq = r_dv_neg[l][MW-1] ? -(18'(w_qf) + 18'(w_nz)) : 18'(w_qf);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_tot[l] <= w_fq + 18'(w_off[l]);
            end
        end
    end

    // Hue modulo 255 by folding bytes, since 256 is one more than 255.
    assign w_hu  = 18'(r_tot[1]) + ppg_pkg::HUE_BIAS;
    assign w_hf1 = 10'(w_hu[17:8]) + 10'(w_hu[7:0]);
    assign w_hf2 = 9'(w_hf1[9:8]) + 9'(w_hf1[7:0]);
    assign w_hue = (w_hf2 >= 9'd255) ? 8'(w_hf2 - 9'd255) : w_hf2[7:0];

    always_comb begin
        priority if (r_tot[0] < 18'sd0) begin
            w_bright = 8'd0;
        end else if (r_tot[0] > 18'sd255) begin
            w_bright = 8'd255;
        end else begin
            w_bright = r_tot[0][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v15      <= w_sum[17:3];
            r_q        <= w_qprod[22:15];
            r_out.hue    <= w_hue;
            r_out.sat    <= r_hue_map[39:32];
            r_out.bright <= w_bright;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NEXT(a_frame_time_hold, i_clk, i_rst_n, !(w_in_acc && i_in_data.frame_start), $stable(r_frame_time))
    `ASSERT_IMPLIES(a_terms_in_step, i_clk, i_rst_n, 1'b1, w_tvld == 4'h0 || w_tvld == 4'hF)
    `ASSERT_IMPLIES(a_hue_range, i_clk, i_rst_n, o_out_valid, o_out_data.hue != 8'd255)

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams pixel coordinates through the plasma generator under several register
// settings and compares every colour with a bit-exact software model.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH     = 1024;
    localparam int LAT       = 130;
    localparam int MAX_CYCLE = 600000;

    class plasma_scoreboard;
        bit [31:0]  frame_time;
        bit [31:0]  time_step;
        bit [15:0]  drift_x, drift_y, scale_a, scale_b;
        bit [7:0]   levels;
        bit [31:0]  bright_map;
        bit [39:0]  hue_map;
        int         quarter_sine[DEPTH+1];
        ppg_pkg::t_pixel_out pending[$];
        int         errors;
        int         mismatches;

        function new();
            bit [63:0] x, x2, f, s, e;
            frame_time = 0;
            time_step  = ppg_pkg::RST_TIME_STEP;
            drift_x    = ppg_pkg::RST_DRIFT;
            drift_y    = ppg_pkg::RST_DRIFT;
            scale_a    = ppg_pkg::RST_SCALE;
            scale_b    = ppg_pkg::RST_SCALE;
            levels     = ppg_pkg::RST_LEVELS;
            bright_map = ppg_pkg::RST_BRIGHT_MAP;
            hue_map    = ppg_pkg::RST_HUE_MAP;
            errors     = 0;
            mismatches = 0;
            for (int i = 0; i <= DEPTH; i++) begin
                x  = (ppg_pkg::HALF_PI_Q30 * i) / DEPTH;
                x2 = (x * x) >> 30;
                f  = ppg_pkg::ONE_Q30 - x2 / 110;
                f  = ppg_pkg::ONE_Q30 - ((x2 * f) >> 30) / 72;
                f  = ppg_pkg::ONE_Q30 - ((x2 * f) >> 30) / 42;
                f  = ppg_pkg::ONE_Q30 - ((x2 * f) >> 30) / 20;
                f  = ppg_pkg::ONE_Q30 - ((x2 * f) >> 30) / 6;
                s  = (x * f) >> 30;
                e  = (s + (1 << 14)) >> 15;
                quarter_sine[i] = (e > 32767) ? 32767 : int'(e);
            end
        endfunction

        function void write_reg(ppg_pkg::t_cfg_idx idx, bit [39:0] v);
            case (idx)
                ppg_pkg::CFG_TIME_STEP:  time_step  = v[31:0];
                ppg_pkg::CFG_DRIFT_X:    drift_x    = v[15:0];
                ppg_pkg::CFG_DRIFT_Y:    drift_y    = v[15:0];
                ppg_pkg::CFG_SCALE_A:    scale_a    = v[15:0];
                ppg_pkg::CFG_SCALE_B:    scale_b    = v[15:0];
                ppg_pkg::CFG_LEVELS:     levels     = v[7:0];
                ppg_pkg::CFG_BRIGHT_MAP: bright_map = v[31:0];
                ppg_pkg::CFG_HUE_MAP:    hue_map    = v;
                default: ;
            endcase
        endfunction

        function longint drift_offset(bit [15:0] drift);
            longint d;
            longint unsigned mag;
            d   = longint'($signed(drift));
            mag = (d < 0) ? -d : d;
            mag = (mag * frame_time) >> 16;
            return (d < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function longint clip_diff(longint v);
            if (v > ppg_pkg::DIFF_MAX) return ppg_pkg::DIFF_MAX;
            if (v < -ppg_pkg::DIFF_MAX) return -ppg_pkg::DIFF_MAX;
            return v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b   = 64'h4000_0000_0000_0000;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function int wave(longint dx, longint dy, bit [15:0] scale);
            longint unsigned sq, radius, ang, turns, idx, quad, r, sc;
            sq     = dx * dx + dy * dy;
            radius = int_sqrt(sq);
            sc     = (scale == 0) ? 1 : scale;
            ang    = ((radius << 16) / sc) % ppg_pkg::TWO_PI_Q16;
            turns  = (ang * ppg_pkg::INV_TWO_PI_Q32) >> 16;
            idx    = (turns * (4 * DEPTH)) >> 32;
            quad   = (idx / DEPTH) & 3;
            r      = idx % DEPTH;
            case (quad)
                0: return quarter_sine[r];
                1: return quarter_sine[DEPTH - r];
                2: return -quarter_sine[r];
                default: return -quarter_sine[DEPTH - r];
            endcase
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q--;
            return q;
        endfunction

        function void note_pixel(ppg_pkg::t_pixel_in p);
            longint x, y, offx, offy, lv, q, boff, brng, b, hoff, hrng, h;
            int sum;
            bit [31:0] v15;
            ppg_pkg::t_pixel_out colour;
            x = longint'(p.pixel_x) * 256;
            y = longint'(p.pixel_y) * 256;
            if (p.frame_start) frame_time = frame_time + time_step;
            offx = drift_offset(drift_x);
            offy = drift_offset(drift_y);
            sum  = wave(clip_diff(x + offx - ppg_pkg::Q8_128), y - ppg_pkg::Q8_128, scale_a);
            sum += wave(x, y, scale_a);
            sum += wave(x - ppg_pkg::Q8_192, y - ppg_pkg::Q8_64, scale_b);
            sum += wave(x - ppg_pkg::Q8_192, clip_diff(y + offy - ppg_pkg::Q8_64), scale_b);
            v15  = sum + 131072;
            v15  = v15 >> 3;
            lv   = (levels == 0) ? 1 : levels;
            q    = (lv * v15 + 16384) >> 15;
            boff = longint'($signed(bright_map[15:0]));
            brng = longint'($signed(bright_map[31:16]));
            b    = floor_div(boff * lv + q * brng, lv);
            if (b < 0) b = 0;
            if (b > 255) b = 255;
            hoff = longint'($signed(hue_map[15:0]));
            hrng = longint'($signed(hue_map[31:16]));
            h    = floor_div(hoff * lv + q * hrng, lv);
            h    = h % 255;
            if (h < 0) h += 255;
            colour.hue    = h[7:0];
            colour.sat    = hue_map[39:32];
            colour.bright = b[7:0];
            pending.push_back(colour);
        endfunction

        function void check_pixel(ppg_pkg::t_pixel_out got);
            ppg_pkg::t_pixel_out want;
            if (pending.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected pixel %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (mismatches++ < 10)
                    $display("pixel mismatch: expected h=%0d s=%0d b=%0d got h=%0d s=%0d b=%0d",
                             want.hue, want.sat, want.bright, got.hue, got.sat, got.bright);
            end
        endfunction
    endclass

    logic                       i_clk = 0;
    logic                       i_rst_n = 0;
    logic                       i_in_valid = 0;
    logic                       o_in_stall;
    ppg_pkg::t_pixel_in         i_in_data = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 0;
    ppg_pkg::t_pixel_out        o_out_data;
    logic                       i_cfg_we = 0;
    logic [2:0]                 i_cfg_idx = '0;
    logic [ppg_pkg::CFG_W-1:0]  i_cfg_data = '0;

    plasma_scoreboard sb = new();
    int cycles = 0;
    int stall_mode = 0;

    plasma_pixel_generator uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver switches between four stall patterns, picked at random.
    always @(negedge i_clk) begin
        if (cycles % 150 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (cycles % 9 < 4);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_pixel(o_out_data);
    end

    task automatic send_pixel(ppg_pkg::t_pixel_in p);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(p);
    endtask

    task automatic pause_input(int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic write_reg(ppg_pkg::t_cfg_idx idx, bit [39:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic drain();
        pause_input(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic send_xy(int x, int y, bit fs);
        ppg_pkg::t_pixel_in p;
        p.pixel_x = 10'(x);
        p.pixel_y = 10'(y);
        p.frame_start = fs;
        send_pixel(p);
    endtask

    // Random stream in bursts; some phases run with no gaps at all.
    task automatic run_pixels(int n);
        int burst;
        bit gapless;
        ppg_pkg::t_pixel_in p;
        gapless = ($urandom_range(0, 3) == 0);
        burst = $urandom_range(1, 20);
        for (int k = 0; k < n; k++) begin
            p.pixel_x = 10'($urandom);
            p.pixel_y = 10'($urandom);
            p.frame_start = ($urandom_range(0, 15) == 0);
            send_pixel(p);
            if (--burst == 0) begin
                if (!gapless) pause_input($urandom_range(0, 6));
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    function automatic bit [39:0] pick(int w);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return (40'd1 << w) - 1;
            2: return 40'd1 << (w - 1);
            3: return ((40'd1 << (w - 1)) - 1);
            default: return 40'({$urandom, $urandom} & ((40'd1 << w) - 1));
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corners of the coordinate range and the fixed points, at reset settings.
        send_xy(0, 0, 0);
        send_xy(1023, 1023, 0);
        send_xy(0, 1023, 1);
        send_xy(1023, 0, 1);
        send_xy(128, 128, 0);
        send_xy(192, 64, 1);
        send_xy(512, 341, 0);
        send_xy(682, 170, 1);
        drain();

        // Maximum step and drift: the frame time wraps and the shifted differences
        // saturate. A zero scale and zero levels act as one; negative hues wrap.
        write_reg(ppg_pkg::CFG_TIME_STEP, 40'hFFFF_FFFF);
        write_reg(ppg_pkg::CFG_DRIFT_X, 40'h7FFF);
        write_reg(ppg_pkg::CFG_DRIFT_Y, 40'h8000);
        write_reg(ppg_pkg::CFG_SCALE_A, 40'h0);
        write_reg(ppg_pkg::CFG_SCALE_B, 40'hFFFF);
        write_reg(ppg_pkg::CFG_LEVELS, 40'h0);
        write_reg(ppg_pkg::CFG_BRIGHT_MAP, 40'h8000_7FFF);
        write_reg(ppg_pkg::CFG_HUE_MAP, 40'hFF_7FFF_8000);
        for (int k = 0; k < 6; k++) send_xy(k * 200, 1023 - k * 200, 1);
        drain();

        write_reg(ppg_pkg::CFG_TIME_STEP, 40'h0);
        write_reg(ppg_pkg::CFG_DRIFT_X, 40'h8000);
        write_reg(ppg_pkg::CFG_DRIFT_Y, 40'h7FFF);
        write_reg(ppg_pkg::CFG_SCALE_A, 40'h1);
        write_reg(ppg_pkg::CFG_SCALE_B, 40'h0);
        write_reg(ppg_pkg::CFG_LEVELS, 40'hFF);
        write_reg(ppg_pkg::CFG_BRIGHT_MAP, 40'h7FFF_8000);
        write_reg(ppg_pkg::CFG_HUE_MAP, 40'h00_8000_7FFF);
        for (int k = 0; k < 6; k++) send_xy(1023 - k * 150, k * 170, k[0]);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(ppg_pkg::CFG_TIME_STEP, pick(32));
            write_reg(ppg_pkg::CFG_DRIFT_X, pick(16));
            write_reg(ppg_pkg::CFG_DRIFT_Y, pick(16));
            write_reg(ppg_pkg::CFG_SCALE_A, pick(16));
            write_reg(ppg_pkg::CFG_SCALE_B, pick(16));
            write_reg(ppg_pkg::CFG_LEVELS, pick(8));
            write_reg(ppg_pkg::CFG_BRIGHT_MAP, pick(32));
            write_reg(ppg_pkg::CFG_HUE_MAP, pick(40));
            run_pixels(113);
            drain();
        end

        sb.errors += sb.pending.size();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
